@@ design/arp_pkg.sv @@
// shared types and constants of the note arpeggiator
package arp_pkg;

    localparam int MAX_HELD   = 16;
    localparam int TIMER_BITS = 24;
    localparam int IDX_W      = $clog2(MAX_HELD);
    localparam int CNT_W      = $clog2(MAX_HELD + 1);
    localparam int CD_W       = TIMER_BITS + 1;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int TLEN_W     = (TIMER_BITS < CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
    localparam int POS_W      = 8;
    localparam int PITCH_W    = 7;
    localparam int NOTE_W     = 8;
    localparam int VEL_W      = 8;
    localparam int SEMITONES  = 12;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_RESET    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION = 2'd0,
        REG_OCTAVES   = 2'd1,
        REG_STEP_LEN  = 2'd2,
        REG_GATE_LEN  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_UP         = 2'd0,
        MODE_DOWN       = 2'd1,
        MODE_UPDOWN     = 2'd2,
        MODE_UPDOWN_REP = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_INSERT,
        OP_DELETE,
        OP_RESET,
        OP_TICK,
        OP_DIV1,
        OP_LIN,
        OP_DIV2,
        OP_PITCH,
        OP_TIMERS,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic scan_more;
        t_cmd cmd;
        logic tick_skip;
        logic need_next;
        logic div_done;
        logic has_event;
        logic out_busy;
    } t_dp_status;

endpackage

@@ design/arp_if.sv @@
// handshake channels for input items and result items
interface arp_in_if;
    import arp_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [PITCH_W-1:0]  pitch;
    logic [VEL_W-1:0]    velocity;
    modport source (output valid, cmd, pitch, velocity, input ready);
    modport sink   (input valid, cmd, pitch, velocity, output ready);
endinterface

interface arp_out_if;
    import arp_pkg::*;
    logic               valid;
    logic               ready;
    logic               off_valid;
    logic [NOTE_W-1:0]  off_pitch;
    logic               on_valid;
    logic [NOTE_W-1:0]  on_pitch;
    logic [VEL_W-1:0]   on_velocity;
    modport source (output valid, off_valid, off_pitch, on_valid, on_pitch, on_velocity,
                    input ready);
    modport sink   (input valid, off_valid, off_pitch, on_valid, on_pitch, on_velocity,
                    output ready);
endinterface

@@ design/note_arpeggiator_core.sv @@
// top level of the note arpeggiator: controller, datapath and ports
//
// channel   dir  handshake            contents
// i_item    in   valid/ready          cmd, pitch, velocity
// o_result  out  valid/ready          off_valid, off_pitch, on_valid, on_pitch, on_velocity
// i_cfg_*   in   write enable only    register index, write data
//
// note on/off search the held set linearly for the pitch position, then insert or delete.
// a tick is skipped on an empty set or a zero step length; otherwise a new note, when due,
// takes two divider runs, the timers count down and a result is emitted only on an event.
// synchronous active-low reset empties the set and loads the register defaults.
// a waiting result holds its register; the next item is taken meanwhile, and
// only a later result stalls until the output register frees.
module note_arpeggiator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    arp_in_if.sink                         i_item,
    arp_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [arp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import arp_pkg::*;

    t_dp_op     op;
    t_dp_status status;

    arp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_status   (status),
        .o_op       (op)
    );

    arp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .o_status      (status),
        .i_cmd         (i_item.cmd),
        .i_pitch       (i_item.pitch),
        .i_velocity    (i_item.velocity),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_off_valid   (o_result.off_valid),
        .o_off_pitch   (o_result.off_pitch),
        .o_on_valid    (o_result.on_valid),
        .o_on_pitch    (o_result.on_pitch),
        .o_on_velocity (o_result.on_velocity)
    );

endmodule

@@ design/arp_div.sv @@
// restoring divider, one quotient bit per cycle
module arp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [arp_pkg::POS_W-1:0]  i_dividend,
    input  logic [arp_pkg::POS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [arp_pkg::POS_W-1:0]  o_quo,
    output logic [arp_pkg::POS_W-1:0]  o_rem
);
    import arp_pkg::*;

    localparam int STEP_W = $clog2(POS_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [POS_W-1:0]  r_quo;
    logic [POS_W-1:0]  r_rem;
    logic [POS_W-1:0]  r_div;
    logic [POS_W:0]    shifted;
    logic [POS_W+1:0]  diff;

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {r_rem, r_quo[POS_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(POS_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!diff[POS_W+1]) begin
                    r_rem <= diff[POS_W-1:0];
                    r_quo <= {r_quo[POS_W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted[POS_W-1:0];
                    r_quo <= {r_quo[POS_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ design/arp_datapath.sv @@
// held set, sequencer timers, pitch selection and result register
module arp_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  arp_pkg::t_dp_op                i_op,
    output arp_pkg::t_dp_status            o_status,
    input  logic [1:0]                     i_cmd,
    input  logic [arp_pkg::PITCH_W-1:0]    i_pitch,
    input  logic [arp_pkg::VEL_W-1:0]      i_velocity,
    input  logic                           i_cfg_we,
    input  logic [arp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_off_valid,
    output logic [arp_pkg::NOTE_W-1:0]     o_off_pitch,
    output logic                           o_on_valid,
    output logic [arp_pkg::NOTE_W-1:0]     o_on_pitch,
    output logic [arp_pkg::VEL_W-1:0]      o_on_velocity
);
    import arp_pkg::*;

    // configuration
    t_mode             r_mode;
    logic [2:0]        r_octaves;
    logic [TLEN_W-1:0] r_step_len;
    logic [TLEN_W-1:0] r_gate_len;

    // latched item and held set
    t_cmd               r_cmd;
    logic [PITCH_W-1:0] r_pitch;
    logic [VEL_W-1:0]   r_vel;
    logic [PITCH_W-1:0] r_held [MAX_HELD];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_pos;

    // sequencer
    logic [POS_W-1:0]   r_step_pos;
    logic [CD_W-1:0]    r_step_cd;
    logic [CD_W-1:0]    r_gate_cd;
    logic               r_sounding;
    logic [8:0]         r_sound_pitch;
    logic [VEL_W-1:0]   r_saved_vel;
    logic [POS_W-1:0]   r_lin;

    // pending result and output register
    logic               r_off_v;
    logic [NOTE_W-1:0]  r_off_p;
    logic               r_on_v;
    logic [NOTE_W-1:0]  r_on_p;
    logic [VEL_W-1:0]   r_on_vel;
    logic               r_out_valid;
    logic               r_o_off_v;
    logic [NOTE_W-1:0]  r_o_off_p;
    logic               r_o_on_v;
    logic [NOTE_W-1:0]  r_o_on_p;
    logic [VEL_W-1:0]   r_o_on_vel;

    logic [IDX_W-1:0]   rd_idx;
    logic [PITCH_W-1:0] rd_data;
    logic               in_range;
    logic               found;
    logic               full;
    logic               step_le0;
    logic               gate_le0;
    logic [2:0]         eff_r;
    logic [CNT_W+2:0]   total_full;
    logic [POS_W:0]     tot9;
    logic [POS_W:0]     s9;
    logic [POS_W:0]     seq9;
    logic [POS_W:0]     lin9;
    logic [POS_W:0]     limit9;
    logic               div_start;
    logic [POS_W-1:0]   div_a;
    logic [POS_W-1:0]   div_b;
    logic               div_done;
    logic [POS_W-1:0]   div_q;
    logic [POS_W-1:0]   div_r;
    logic [POS_W-1:0]   q12;
    logic [NOTE_W-1:0]  next_p;

    // single read port on the held set
    assign rd_idx   = (i_op == OP_PITCH) ? div_r[IDX_W-1:0] : r_pos[IDX_W-1:0];
    assign rd_data  = r_held[rd_idx];
    assign in_range = r_pos < r_count;
    assign found    = in_range && (rd_data == r_pitch);
    assign full     = r_count >= CNT_W'(MAX_HELD);

    assign step_le0 = r_step_cd[CD_W-1] || (r_step_cd == '0);
    assign gate_le0 = r_gate_cd[CD_W-1] || (r_gate_cd == '0);

    // pattern length and position arithmetic
    assign eff_r      = (r_octaves == 3'd0) ? 3'd1 : r_octaves;
    assign total_full = r_count * eff_r;
    assign tot9       = (POS_W + 1)'(total_full);
    assign s9         = {1'b0, r_step_pos};

    always_comb begin
        seq9 = (POS_W + 1)'(1);
        if (tot9 > (POS_W + 1)'(1)) begin
            unique case (r_mode)
                MODE_UPDOWN:     seq9 = (tot9 << 1) - (POS_W + 1)'(2);
                MODE_UPDOWN_REP: seq9 = tot9 << 1;
                default:         seq9 = (POS_W + 1)'(1);
            endcase
        end
    end

    always_comb begin
        lin9   = s9;
        limit9 = tot9;
        unique case (r_mode)
            MODE_UP: begin
                lin9   = s9;
                limit9 = tot9;
            end
            MODE_DOWN: begin
                lin9   = (s9 + 1'b1 > tot9) ? '0 : tot9 - 1'b1 - s9;
                limit9 = tot9;
            end
            MODE_UPDOWN: begin
                lin9   = {1'b0, div_r};
                if (lin9 >= tot9) lin9 = (tot9 << 1) - (POS_W + 1)'(2) - {1'b0, div_r};
                limit9 = seq9;
            end
            MODE_UPDOWN_REP: begin
                lin9   = {1'b0, div_r};
                if (lin9 >= tot9) lin9 = (tot9 << 1) - (POS_W + 1)'(1) - {1'b0, div_r};
                limit9 = seq9;
            end
        endcase
    end

    // shared divider: position by cycle length, then index by note count
    assign div_start = (i_op == OP_DIV1) || (i_op == OP_DIV2);
    assign div_a     = (i_op == OP_DIV1) ? r_step_pos : r_lin;
    assign div_b     = (i_op == OP_DIV1) ? seq9[POS_W-1:0] : POS_W'(r_count);

    arp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quo      (div_q),
        .o_rem      (div_r)
    );

    assign q12    = POS_W'(div_q * POS_W'(SEMITONES));
    assign next_p = NOTE_W'({1'b0, rd_data}) + NOTE_W'(q12);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_UP;
            r_octaves  <= 3'd1;
            r_step_len <= TLEN_W'(11025);
            r_gate_len <= TLEN_W'(5512);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DIRECTION: r_mode     <= t_mode'(i_cfg_data[1:0]);
                REG_OCTAVES:   r_octaves  <= i_cfg_data[2:0];
                REG_STEP_LEN:  r_step_len <= i_cfg_data[TLEN_W-1:0];
                REG_GATE_LEN:  r_gate_len <= i_cfg_data[TLEN_W-1:0];
            endcase
        end
    end

    // held set storage, shifted in place on insert and delete
    always_ff @(posedge i_clk) begin
        if (i_op == OP_INSERT && !found && !full) begin
            if (r_pos == '0) r_held[0] <= r_pitch;
            for (int i = 1; i < MAX_HELD; i++) begin
                if (CNT_W'(i) == r_pos) r_held[i] <= r_pitch;
                else if (CNT_W'(i) > r_pos) r_held[i] <= r_held[i-1];
            end
        end else if (i_op == OP_DELETE && found) begin
            for (int i = 0; i < MAX_HELD - 1; i++) begin
                if (CNT_W'(i) >= r_pos) r_held[i] <= r_held[i+1];
            end
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_pitch <= i_pitch;
            r_vel   <= i_velocity;
        end
    end

    // control state of set and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_pos         <= '0;
            r_step_pos    <= '0;
            r_step_cd     <= '0;
            r_gate_cd     <= '0;
            r_sounding    <= 1'b0;
            r_sound_pitch <= '1;
            r_saved_vel   <= '0;
            r_off_v       <= 1'b0;
            r_on_v        <= 1'b0;
        end else begin
            unique case (i_op)
                OP_LOAD: r_pos <= '0;
                OP_SCAN: if (in_range && rd_data < r_pitch) r_pos <= r_pos + 1'b1;
                OP_INSERT: begin
                    r_saved_vel <= r_vel;
                    if (!found && !full) begin
                        r_count <= r_count + 1'b1;
                        if (r_count == '0) begin
                            r_step_pos    <= '0;
                            r_step_cd     <= '0;
                            r_gate_cd     <= '0;
                            r_sounding    <= 1'b0;
                            r_sound_pitch <= '1;
                        end
                    end
                end
                OP_DELETE: begin
                    if (found) r_count <= r_count - 1'b1;
                    if (r_count == '0 || (found && r_count == CNT_W'(1))) begin
                        r_step_pos    <= '0;
                        r_step_cd     <= '0;
                        r_gate_cd     <= '0;
                        r_sounding    <= 1'b0;
                        r_sound_pitch <= '1;
                    end
                end
                OP_RESET: begin
                    r_count       <= '0;
                    r_step_pos    <= '0;
                    r_step_cd     <= '0;
                    r_gate_cd     <= '0;
                    r_sounding    <= 1'b0;
                    r_sound_pitch <= '1;
                end
                OP_TICK: begin
                    r_off_v  <= r_sounding && (gate_le0 || step_le0);
                    r_off_p  <= (r_sounding && (gate_le0 || step_le0)) ?
                                r_sound_pitch[NOTE_W-1:0] : '0;
                    r_on_v   <= 1'b0;
                    r_on_p   <= '0;
                    r_on_vel <= '0;
                    if (gate_le0 || step_le0) r_sounding <= 1'b0;
                end
                OP_LIN: begin
                    r_lin      <= lin9[POS_W-1:0];
                    r_step_pos <= (s9 + 1'b1 >= limit9) ? '0 : r_step_pos + 1'b1;
                end
                OP_PITCH: begin
                    r_on_v        <= 1'b1;
                    r_on_p        <= next_p;
                    r_on_vel      <= r_saved_vel;
                    r_sounding    <= 1'b1;
                    r_sound_pitch <= {1'b0, next_p};
                    r_step_cd     <= CD_W'(r_step_len);
                    r_gate_cd     <= CD_W'(r_gate_len);
                end
                OP_TIMERS: begin
                    r_step_cd <= r_step_cd - 1'b1;
                    if (r_sounding) r_gate_cd <= r_gate_cd - 1'b1;
                end
                default: ;
            endcase
        end
    end

    // output register, freed by the downstream handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_EMIT) begin
            r_o_off_v  <= r_off_v;
            r_o_off_p  <= r_off_p;
            r_o_on_v   <= r_on_v;
            r_o_on_p   <= r_on_p;
            r_o_on_vel <= r_on_vel;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_off_valid   = r_o_off_v;
    assign o_off_pitch   = r_o_off_p;
    assign o_on_valid    = r_o_on_v;
    assign o_on_pitch    = r_o_on_p;
    assign o_on_velocity = r_o_on_vel;

    // status to the controller
    assign o_status.scan_more = in_range && (rd_data < r_pitch);
    assign o_status.cmd       = r_cmd;
    assign o_status.tick_skip = (r_count == '0) || (r_step_len == '0);
    assign o_status.need_next = step_le0;
    assign o_status.div_done  = div_done;
    assign o_status.has_event = r_off_v || r_on_v;
    assign o_status.out_busy  = r_out_valid;

endmodule

@@ design/arp_ctrl.sv @@
// sequencing state machine for one item at a time
module arp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  arp_pkg::t_dp_status  i_status,
    output arp_pkg::t_dp_op      o_op
);
    import arp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN, S_INS, S_DEL, S_RST, S_TICK,
        S_DIV1, S_WAIT1, S_LIN, S_DIV2, S_WAIT2, S_PITCH, S_TIMERS, S_EMIT
    } t_state;

    t_state r_state;

    // command decode from state
    always_comb begin
        unique case (r_state)
            S_IDLE:   o_op = i_in_valid ? OP_LOAD : OP_NONE;
            S_SCAN:   o_op = OP_SCAN;
            S_INS:    o_op = OP_INSERT;
            S_DEL:    o_op = OP_DELETE;
            S_RST:    o_op = OP_RESET;
            S_TICK:   o_op = i_status.tick_skip ? OP_NONE : OP_TICK;
            S_DIV1:   o_op = OP_DIV1;
            S_LIN:    o_op = OP_LIN;
            S_DIV2:   o_op = OP_DIV2;
            S_PITCH:  o_op = OP_PITCH;
            S_TIMERS: o_op = OP_TIMERS;
            S_EMIT:   o_op = i_status.out_busy ? OP_NONE : OP_EMIT;
            default:  o_op = OP_NONE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    unique case (i_status.cmd)
                        CMD_NOTE_ON, CMD_NOTE_OFF: r_state <= S_SCAN;
                        CMD_TICK:                  r_state <= S_TICK;
                        CMD_RESET:                 r_state <= S_RST;
                    endcase
                end
                S_SCAN: begin
                    if (!i_status.scan_more) begin
                        r_state <= (i_status.cmd == CMD_NOTE_ON) ? S_INS : S_DEL;
                    end
                end
                S_INS, S_DEL, S_RST: r_state <= S_IDLE;
                S_TICK: begin
                    priority if (i_status.tick_skip) r_state <= S_IDLE;
                    else if (i_status.need_next)     r_state <= S_DIV1;
                    else                             r_state <= S_TIMERS;
                end
                S_DIV1:   r_state <= S_WAIT1;
                S_WAIT1:  if (i_status.div_done) r_state <= S_LIN;
                S_LIN:    r_state <= S_DIV2;
                S_DIV2:   r_state <= S_WAIT2;
                S_WAIT2:  if (i_status.div_done) r_state <= S_PITCH;
                S_PITCH:  r_state <= S_TIMERS;
                S_TIMERS: r_state <= i_status.has_event ? S_EMIT : S_IDLE;
                S_EMIT:   if (!i_status.out_busy) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sim/note_arpeggiator_core_tb.sv @@
// testbench for the note arpeggiator: directed and random items checked against a local predictor
module note_arpeggiator_core_tb;
    import arp_pkg::*;

    // expected output event of one tick
    typedef struct packed {
        logic             off_valid;
        logic [NOTE_W-1:0] off_pitch;
        logic             on_valid;
        logic [NOTE_W-1:0] on_pitch;
        logic [VEL_W-1:0] on_velocity;
    } t_event;

    // scoreboard: arpeggiator predictor plus queue of expected events
    class arp_scoreboard;
        logic [1:0]         mode;
        logic [2:0]         octaves;
        logic [23:0]        step_len;
        logic [23:0]        gate_len;
        logic [PITCH_W-1:0] held [MAX_HELD];
        int unsigned        held_n;
        int unsigned        position;
        longint             step_cd;
        longint             gate_cd;
        bit                 sounding;
        logic [8:0]         sound_pitch;
        logic [VEL_W-1:0]   velocity;
        t_event             pending [$];
        int                 errors;
        int                 events_seen;

        function void init();
            mode = MODE_UP;
            octaves = 3'd1;
            step_len = 24'd11025;
            gate_len = 24'd5512;
            held_n = 0;
            velocity = '0;
            errors = 0;
            events_seen = 0;
            pending.delete();
            clear_seq();
        endfunction

        function void clear_seq();
            position = 0;
            step_cd = 0;
            gate_cd = 0;
            sounding = 0;
            sound_pitch = 9'h1FF;
        endfunction

        function void set_reg(t_reg_idx idx, logic [23:0] data);
            case (idx)
                REG_DIRECTION: mode = data[1:0];
                REG_OCTAVES:   octaves = data[2:0];
                REG_STEP_LEN:  step_len = data;
                default:       gate_len = data;
            endcase
        endfunction

        // pick the next pitch and advance the step position
        function logic [NOTE_W-1:0] advance();
            int unsigned r, total, s, lin, seq, limit;
            r = (octaves == 0) ? 1 : octaves;
            total = held_n * r;
            s = position;
            seq = 1;
            case (t_mode'(mode))
                MODE_UP: begin
                    lin = s;
                    limit = total;
                end
                MODE_DOWN: begin
                    lin = (s + 1 > total) ? 0 : total - 1 - s;
                    limit = total;
                end
                MODE_UPDOWN: begin
                    if (total > 1) seq = 2 * total - 2;
                    lin = s % seq;
                    if (lin >= total) lin = 2 * total - 2 - lin;
                    limit = seq;
                end
                default: begin
                    if (total > 1) seq = 2 * total;
                    lin = s % seq;
                    if (lin >= total) lin = 2 * total - 1 - lin;
                    limit = seq;
                end
            endcase
            s++;
            position = (s >= limit) ? 0 : s;
            return NOTE_W'(held[lin % held_n] + SEMITONES * (lin / held_n));
        endfunction

        // note an accepted input item
        function void note_item(t_cmd cmd, logic [PITCH_W-1:0] pitch, logic [VEL_W-1:0] vel);
            int unsigned pos;
            t_event ev;
            pos = 0;
            ev = '0;
            case (cmd)
                CMD_NOTE_ON: begin
                    velocity = vel;
                    while (pos < held_n && held[pos] < pitch) pos++;
                    if (!(pos < held_n && held[pos] == pitch) && held_n < MAX_HELD) begin
                        for (int i = held_n; i > pos; i--) held[i] = held[i-1];
                        held[pos] = pitch;
                        held_n++;
                        if (held_n == 1) clear_seq();
                    end
                end
                CMD_NOTE_OFF: begin
                    while (pos < held_n && held[pos] < pitch) pos++;
                    if (pos < held_n && held[pos] == pitch) begin
                        for (int i = pos; i < held_n - 1; i++) held[i] = held[i+1];
                        held_n--;
                    end
                    if (held_n == 0) clear_seq();
                end
                CMD_RESET: begin
                    held_n = 0;
                    clear_seq();
                end
                default: begin
                    if (held_n != 0 && step_len != 0) begin
                        if (sounding && gate_cd <= 0) begin
                            ev.off_valid = 1;
                            ev.off_pitch = sound_pitch[7:0];
                            sounding = 0;
                        end
                        if (step_cd <= 0) begin
                            if (sounding) begin
                                ev.off_valid = 1;
                                ev.off_pitch = sound_pitch[7:0];
                                sounding = 0;
                            end
                            ev.on_pitch = advance();
                            ev.on_valid = 1;
                            ev.on_velocity = velocity;
                            sound_pitch = {1'b0, ev.on_pitch};
                            sounding = 1;
                            step_cd = step_len;
                            gate_cd = gate_len;
                        end
                        step_cd -= 1;
                        if (sounding) gate_cd -= 1;
                        if (ev.off_valid || ev.on_valid) pending.push_back(ev);
                    end
                end
            endcase
        endfunction

        function void report(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            errors++;
        endfunction

        // compare one output event with the oldest expectation
        function void check_event(t_event got);
            t_event want;
            events_seen++;
            if (pending.size() == 0) begin
                report("unexpected event, off_pitch", got.off_pitch, -1);
                return;
            end
            want = pending.pop_front();
            if (got.off_valid != want.off_valid) report("off_valid", got.off_valid, want.off_valid);
            if (got.off_pitch != want.off_pitch) report("off_pitch", got.off_pitch, want.off_pitch);
            if (got.on_valid != want.on_valid) report("on_valid", got.on_valid, want.on_valid);
            if (got.on_pitch != want.on_pitch) report("on_pitch", got.on_pitch, want.on_pitch);
            if (got.on_velocity != want.on_velocity)
                report("on_velocity", got.on_velocity, want.on_velocity);
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    arp_in_if  item_ch ();
    arp_out_if result_ch ();

    note_arpeggiator_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch.sink),
        .o_result   (result_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    arp_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  items_sent;
    int  idle_cycles = 0;
    bit  timed_out;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready)
                sb.note_item(t_cmd'(item_ch.cmd), item_ch.pitch, item_ch.velocity);
            if (result_ch.valid && result_ch.ready)
                sb.check_event('{result_ch.off_valid, result_ch.off_pitch, result_ch.on_valid,
                                 result_ch.on_pitch, result_ch.on_velocity});
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stalls at random
    always @(negedge i_clk)
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays up after the accepting edge; the task returns at the next falling edge
    task automatic send_item(t_cmd cmd, logic [PITCH_W-1:0] pitch, logic [VEL_W-1:0] vel);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.cmd      <= cmd;
        item_ch.pitch    <= pitch;
        item_ch.velocity <= vel;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [23:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // let the block drain before touching registers
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic configure(logic [1:0] mode, logic [2:0] oct, logic [23:0] stp,
                             logic [23:0] gate);
        drain();
        write_reg(REG_DIRECTION, 24'(mode));
        write_reg(REG_OCTAVES, 24'(oct));
        write_reg(REG_STEP_LEN, stp);
        write_reg(REG_GATE_LEN, gate);
        i_cfg_we <= 1'b0;
    endtask

    // random item, mostly ticks with a well-kept chord
    task automatic random_item();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            send_item(CMD_TICK, 7'($urandom), 8'($urandom));
        else if (sel < 78)
            send_item(CMD_NOTE_ON, 7'($urandom), 8'($urandom));
        else if (sel < 97)
            send_item(CMD_NOTE_OFF, (sb.held_n != 0 && $urandom_range(3) != 0) ?
                      sb.held[$urandom_range(sb.held_n - 1)] : 7'($urandom), 8'($urandom));
        else
            send_item(CMD_RESET, 7'($urandom), 8'($urandom));
    endtask

    initial begin
        sb = new();
        sb.init();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        item_ch.valid = 1'b0;
        item_ch.cmd = CMD_TICK;
        item_ch.pitch = '0;
        item_ch.velocity = '0;
        result_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_DIRECTION;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: short timers, extremes, duplicates, full set, stray note-off
        configure(MODE_UP, 3'd4, 24'd2, 24'd0);
        send_item(CMD_TICK, 7'd0, 8'd0);
        send_item(CMD_NOTE_OFF, 7'd5, 8'd0);
        send_item(CMD_NOTE_ON, 7'd127, 8'd255);
        send_item(CMD_NOTE_ON, 7'd0, 8'd1);
        send_item(CMD_NOTE_ON, 7'd127, 8'd128);
        for (int i = 0; i < 5; i++) send_item(CMD_TICK, 7'h7F, 8'hFF);
        for (int i = 0; i < 16; i++) send_item(CMD_NOTE_ON, 7'(i * 7 + 3), 8'(i));
        send_item(CMD_TICK, 7'd0, 8'd0);
        send_item(CMD_NOTE_OFF, 7'd60, 8'd0);
        send_item(CMD_RESET, 7'd0, 8'd0);
        send_item(CMD_TICK, 7'd0, 8'd0);
        configure(MODE_DOWN, 3'd0, 24'd0, 24'hFFFFFF);
        send_item(CMD_NOTE_ON, 7'd64, 8'd77);
        send_item(CMD_TICK, 7'd0, 8'd0);
        configure(MODE_DOWN, 3'd7, 24'hFFFFFF, 24'hFFFFFF);
        send_item(CMD_TICK, 7'd0, 8'd0);
        send_item(CMD_NOTE_OFF, 7'd64, 8'd0);

        // random phases across settings and idle patterns
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            configure(2'(ph), 3'($urandom_range(1, 4)), 24'($urandom_range(1, 4)),
                      24'($urandom_range(0, 3)));
            for (int i = 0; i < 75; i++) random_item();
        end

        drain();
        $display("ran %0d items over all directions, octave ranges and idle patterns",
                 items_sent);
        $display("%0d note events checked, %0d mismatches", sb.events_seen, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
